@@ src/assert_macros.svh @@
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define VPA_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ src/vpa_pkg.sv @@
// Types, constants and control structs of the variable partition allocator.
package vpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_W     = 16;
    localparam int ID_W       = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [ADDR_W-1:0] REGION_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_ALLOC = 3'd0,
        ST_NOFIT = 3'd1,
        ST_FREED = 3'd2,
        ST_BADID = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [ID_W-1:0]   id;
        logic              used;
    } entry_t;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] req_size;
        logic [ID_W-1:0]   block_id;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   new_id;
        logic [ADDR_W-1:0] start_addr;
    } out_item_t;

    typedef struct packed {
        logic    init_wr;
        logic    load;
        logic    scan;
        logic    shup_init;
        logic    shup;
        logic    wr_rest;
        logic    wr_pick;
        logic    nrd;
        logic    merge;
        logic    shdn;
        logic    respond;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic zero_req;
        logic need_split;
        logic full;
        logic is_free;
        logic shup_done;
        logic shdn_done;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ src/vpa_dp.sv @@
// Datapath: block table memory, scan and shift counters, result register.
`include "assert_macros.svh"

module vpa_dp
    import vpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    entry_t mem [MAX_BLOCKS];
    entry_t rdata_reg;

    in_item_t          item_reg;
    logic [1:0]        fit_reg;
    logic [ADDR_W-1:0] region_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ID_W-1:0]   nid_reg;
    logic [ID_W-1:0]   alloc_id_reg;

    logic [CNT_W-1:0]  rd_ptr_reg;
    logic              ev_vld_reg;
    logic [CNT_W-1:0]  ev_idx_reg;
    logic              wvld_reg;
    logic [CNT_W-1:0]  wdst_reg;

    logic              found_reg;
    logic [CNT_W-1:0]  pick_reg;
    entry_t            pick_ent_reg;
    entry_t            prev_ent_reg;
    entry_t            pick_prev_reg;
    logic [1:0]        rem_reg;

    out_item_t         out_reg;
    logic              out_vld_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic [CNT_W-1:0]  pick_inc;
    logic [CNT_W-1:0]  rd_dec;
    logic              stop;
    logic              hit;
    logic              alloc_ok;
    logic              cfg_region;
    logic              has_next;
    logic              next_free;
    logic              prev_free;
    logic [CNT_W-1:0]  lo;
    logic [1:0]        rem;
    entry_t            merged;

    assign pick_inc   = pick_reg + CNT_W'(1);
    assign rd_dec     = rd_ptr_reg - CNT_W'(1);
    assign cfg_region = cfg_valid && cfg_ready && (cfg_index == CFG_REGION);
    assign stop       = found_reg && (item_reg.func || (fit_reg == FIT_FIRST));
    assign alloc_ok   = !rdata_reg.used && (rdata_reg.size >= item_reg.req_size);

    always_comb begin
        if (item_reg.func) begin
            hit = rdata_reg.used && (rdata_reg.id == item_reg.block_id);
        end else begin
            case (fit_reg)
                FIT_FIRST: hit = alloc_ok;
                FIT_BEST:  hit = alloc_ok && (!found_reg || rdata_reg.size < pick_ent_reg.size);
                FIT_WORST: hit = alloc_ok && (!found_reg || rdata_reg.size > pick_ent_reg.size);
                default:   hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        has_next     = pick_inc < cnt_reg;
        next_free    = has_next && !rdata_reg.used;
        prev_free    = (pick_reg != '0) && !pick_prev_reg.used;
        lo           = prev_free ? pick_reg - CNT_W'(1) : pick_reg;
        rem          = {1'b0, prev_free} + {1'b0, next_free};
        merged.start = prev_free ? pick_prev_reg.start : pick_ent_reg.start;
        merged.size  = pick_ent_reg.size
                     + (prev_free ? pick_prev_reg.size : '0)
                     + (next_free ? rdata_reg.size : '0);
        merged.id    = '0;
        merged.used  = 1'b0;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = rd_ptr_reg[IDX_W-1:0];
        if (cmd.scan) begin
            rd_en = (rd_ptr_reg < cnt_reg) && !stop;
        end else if (cmd.shup) begin
            rd_en   = rd_ptr_reg > pick_inc;
            rd_addr = rd_dec[IDX_W-1:0];
        end else if (cmd.nrd) begin
            rd_en   = 1'b1;
            rd_addr = pick_inc[IDX_W-1:0];
        end else if (cmd.shdn) begin
            rd_en = rd_ptr_reg < cnt_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cfg_region) begin
            wr_en        = 1'b1;
            wr_data.size = cfg_data;
        end else if (cmd.init_wr) begin
            wr_en        = 1'b1;
            wr_data.size = region_reg;
        end else if ((cmd.shup || cmd.shdn) && wvld_reg) begin
            wr_en   = 1'b1;
            wr_addr = wdst_reg[IDX_W-1:0];
            wr_data = rdata_reg;
        end else if (cmd.wr_rest) begin
            wr_en         = 1'b1;
            wr_addr       = pick_inc[IDX_W-1:0];
            wr_data.start = pick_ent_reg.start + item_reg.req_size;
            wr_data.size  = pick_ent_reg.size - item_reg.req_size;
        end else if (cmd.wr_pick) begin
            wr_en         = 1'b1;
            wr_addr       = pick_reg[IDX_W-1:0];
            wr_data.start = pick_ent_reg.start;
            wr_data.size  = item_reg.req_size;
            wr_data.id    = nid_reg;
            wr_data.used  = 1'b1;
        end else if (cmd.merge) begin
            wr_en   = 1'b1;
            wr_addr = lo[IDX_W-1:0];
            wr_data = merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg     <= FIT_FIRST;
            region_reg  <= REGION_RESET;
            cnt_reg     <= CNT_W'(1);
            nid_reg     <= ID_W'(1);
            ev_vld_reg  <= 1'b0;
            wvld_reg    <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index == CFG_FIT) begin
                fit_reg <= cfg_data[1:0];
            end
            if (cfg_region) begin
                region_reg <= cfg_data;
                cnt_reg    <= CNT_W'(1);
                nid_reg    <= ID_W'(1);
            end
            if (cmd.init_wr) begin
                cnt_reg <= CNT_W'(1);
                nid_reg <= ID_W'(1);
            end
            if (cmd.load) begin
                item_reg   <= s_data;
                found_reg  <= 1'b0;
                rd_ptr_reg <= '0;
                ev_vld_reg <= 1'b0;
            end
            if (cmd.scan) begin
                ev_vld_reg <= rd_en;
                ev_idx_reg <= rd_ptr_reg;
                if (rd_en) begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
                if (ev_vld_reg && !stop) begin
                    prev_ent_reg <= rdata_reg;
                    if (hit) begin
                        found_reg     <= 1'b1;
                        pick_reg      <= ev_idx_reg;
                        pick_ent_reg  <= rdata_reg;
                        pick_prev_reg <= prev_ent_reg;
                    end
                end
            end
            if (cmd.shup_init) begin
                rd_ptr_reg <= cnt_reg;
                wvld_reg   <= 1'b0;
            end
            if (cmd.shup) begin
                wvld_reg <= rd_en;
                wdst_reg <= rd_ptr_reg;
                if (rd_en) begin
                    rd_ptr_reg <= rd_dec;
                end
            end
            if (cmd.wr_rest) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.wr_pick) begin
                alloc_id_reg <= nid_reg;
                nid_reg      <= (nid_reg == '1) ? ID_W'(1) : nid_reg + ID_W'(1);
            end
            if (cmd.merge) begin
                rem_reg    <= rem;
                rd_ptr_reg <= lo + CNT_W'(1) + CNT_W'(rem);
                wvld_reg   <= 1'b0;
            end
            if (cmd.shdn) begin
                wvld_reg <= rd_en;
                wdst_reg <= rd_ptr_reg - CNT_W'(rem_reg);
                if (rd_en) begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
                if (stat.shdn_done) begin
                    cnt_reg <= cnt_reg - CNT_W'(rem_reg);
                end
            end
            if (cmd.respond) begin
                out_vld_reg        <= 1'b1;
                out_reg.status     <= cmd.code;
                out_reg.new_id     <= (cmd.code == ST_ALLOC) ? alloc_id_reg : '0;
                out_reg.start_addr <= (cmd.code == ST_ALLOC) ? pick_ent_reg.start : '0;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_done  = stop || (!(rd_ptr_reg < cnt_reg) && !ev_vld_reg);
    assign stat.found      = found_reg;
    assign stat.zero_req   = item_reg.req_size == '0;
    assign stat.need_split = pick_ent_reg.size > item_reg.req_size;
    assign stat.full       = cnt_reg >= CNT_W'(MAX_BLOCKS);
    assign stat.is_free    = item_reg.func;
    assign stat.shup_done  = !(rd_ptr_reg > pick_inc) && !wvld_reg;
    assign stat.shdn_done  = !(rd_ptr_reg < cnt_reg) && !wvld_reg;
    assign stat.out_busy   = out_vld_reg && !m_ready;

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    `VPA_NEVER(a_cnt_range, aclk, aresetn, (cnt_reg > CNT_W'(MAX_BLOCKS)) || (cnt_reg == '0), "Entry count out of range.")
    `VPA_ASSERT(a_port_clash, aclk, aresetn, (wr_en && rd_en) |-> (wr_addr != rd_addr), "Read and write hit one entry.")
    `VPA_ASSERT(a_no_overwrite, aclk, aresetn, cmd.respond |-> !(out_vld_reg && !m_ready), "Result overwritten.")

endmodule

@@ src/vpa_ctrl.sv @@
// Controller: sequences scan, shift and write steps of each request.
`include "assert_macros.svh"

module vpa_ctrl
    import vpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     cfg_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_WREST,
        S_WPICK,
        S_NRD,
        S_MERGE,
        S_SHDN,
        S_RESP
    } state_t;

    state_t  state_reg;
    status_t code_reg;
    logic    accept;

    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = (state_reg == S_IDLE) && !s_valid;
    assign accept    = s_valid && s_ready;

    always_comb begin
        cmd      = '0;
        cmd.code = code_reg;
        case (state_reg)
            S_INIT:   cmd.init_wr = 1'b1;
            S_IDLE:   cmd.load    = s_valid;
            S_SCAN:   cmd.scan    = 1'b1;
            S_DECIDE: cmd.shup_init = !stat.is_free && stat.found && !stat.zero_req
                                      && stat.need_split && !stat.full;
            S_SHUP:   cmd.shup    = 1'b1;
            S_WREST:  cmd.wr_rest = 1'b1;
            S_WPICK:  cmd.wr_pick = 1'b1;
            S_NRD:    cmd.nrd     = 1'b1;
            S_MERGE:  cmd.merge   = 1'b1;
            S_SHDN:   cmd.shdn    = 1'b1;
            S_RESP:   cmd.respond = !stat.out_busy;
            default:  cmd.code    = code_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            code_reg  <= ST_NOFIT;
        end else begin
            case (state_reg)
                S_INIT: begin
                    state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (stat.scan_done) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (stat.is_free) begin
                        if (stat.found) begin
                            state_reg <= S_NRD;
                        end else begin
                            code_reg  <= ST_BADID;
                            state_reg <= S_RESP;
                        end
                    end else if (stat.zero_req || !stat.found) begin
                        code_reg  <= ST_NOFIT;
                        state_reg <= S_RESP;
                    end else if (stat.need_split) begin
                        if (stat.full) begin
                            code_reg  <= ST_FULL;
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_SHUP;
                        end
                    end else begin
                        state_reg <= S_WPICK;
                    end
                end
                S_SHUP: begin
                    if (stat.shup_done) begin
                        state_reg <= S_WREST;
                    end
                end
                S_WREST: begin
                    state_reg <= S_WPICK;
                end
                S_WPICK: begin
                    code_reg  <= ST_ALLOC;
                    state_reg <= S_RESP;
                end
                S_NRD: begin
                    state_reg <= S_MERGE;
                end
                S_MERGE: begin
                    state_reg <= S_SHDN;
                end
                S_SHDN: begin
                    if (stat.shdn_done) begin
                        code_reg  <= ST_FREED;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!stat.out_busy) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `VPA_ASSERT(a_scan, aclk, aresetn, accept |=> (state_reg == S_SCAN), "No scan after accept.")

endmodule

@@ src/variable_partition_allocator.sv @@
// Top level of the first, best and worst fit variable partition allocator.
//
//   channel   ports                          carries
//   input     s_valid  s_ready  s_data       allocate or free request item
//   result    m_valid  m_ready  m_data       status, new id, start address
//   config    cfg_valid cfg_ready cfg_index  fit mode or region size write
//             cfg_data
//
// An item scans a table of N entries, then moves entries when a split inserts or a merge
// removes entries; scan and moves all go through the single read and single write port
// of the block table memory.
// After reset the initial free block is written before items are taken.
// A waiting result does not stall the next item until that item's own result is due.
module variable_partition_allocator
    import vpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    vpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    vpa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the variable partition allocator: directed rows, then random.
module tb;
    import vpa_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [ID_W-1:0]   id;
        logic              used;
    } part_t;

    typedef struct {
        logic              func;
        logic [ADDR_W-1:0] req;
        logic [ID_W-1:0]   bid;
        logic              known;
        status_t           st;
        logic [ID_W-1:0]   nid;
        logic [ADDR_W-1:0] saddr;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    part_t parts[MAX_BLOCKS];
    int part_count;
    logic [ID_W-1:0] id_counter;
    logic [1:0] fit_sel;
    logic [ADDR_W-1:0] region;
    logic [ID_W-1:0] live_ids[$];

    out_item_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;

    variable_partition_allocator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("variable_partition_allocator test failed");
            $finish;
        end
    end

    function automatic void table_init();
        part_count = 1;
        parts[0] = '{start: '0, size: region, id: '0, used: 1'b0};
        id_counter = 1;
        live_ids.delete();
    endfunction

    function automatic void drop_part(int i);
        for (int k = i; k < part_count - 1; k++) parts[k] = parts[k + 1];
        part_count--;
    endfunction

    function automatic out_item_t predict_alloc(logic [ADDR_W-1:0] req);
        out_item_t r;
        int pick;
        logic found;
        logic [ADDR_W-1:0] best;
        r = '{status: ST_NOFIT, new_id: '0, start_addr: '0};
        found = 1'b0;
        pick = 0;
        best = '0;
        if (req == 0) return r;
        for (int i = 0; i < part_count; i++) begin
            if (parts[i].used || parts[i].size < req) continue;
            if (fit_sel == FIT_FIRST) begin
                pick = i; found = 1'b1; break;
            end else if (fit_sel == FIT_BEST) begin
                if (!found || parts[i].size < best) begin
                    best = parts[i].size; pick = i; found = 1'b1;
                end
            end else if (fit_sel == FIT_WORST) begin
                if (!found || parts[i].size > best) begin
                    best = parts[i].size; pick = i; found = 1'b1;
                end
            end
        end
        if (!found) return r;
        if (parts[pick].size > req) begin
            if (part_count >= MAX_BLOCKS) begin
                r.status = ST_FULL;
                return r;
            end
            for (int k = part_count; k > pick + 1; k--) parts[k] = parts[k - 1];
            parts[pick + 1] = '{start: parts[pick].start + req,
                                size: parts[pick].size - req, id: '0, used: 1'b0};
            part_count++;
        end
        r = '{status: ST_ALLOC, new_id: id_counter, start_addr: parts[pick].start};
        live_ids = {live_ids, id_counter};
        id_counter = (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 1'b1;
        parts[pick].size = req;
        parts[pick].id = r.new_id;
        parts[pick].used = 1'b1;
        return r;
    endfunction

    function automatic out_item_t predict_free(logic [ID_W-1:0] bid);
        out_item_t r;
        r = '{status: ST_BADID, new_id: '0, start_addr: '0};
        for (int i = 0; i < part_count; i++) begin
            if (parts[i].used && parts[i].id == bid) begin
                parts[i].used = 1'b0;
                parts[i].id = '0;
                if (i + 1 < part_count && !parts[i + 1].used) begin
                    parts[i].size += parts[i + 1].size;
                    drop_part(i + 1);
                end
                if (i > 0 && !parts[i - 1].used) begin
                    parts[i - 1].size += parts[i].size;
                    drop_part(i);
                end
                r.status = ST_FREED;
                return r;
            end
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIT) begin
            fit_sel = val[1:0];
        end else begin
            region = val;
            table_init();
        end
        @(posedge aclk);
    endtask

    // Returns with valid still high so back-to-back items keep it asserted.
    task automatic send_item(logic func, logic [ADDR_W-1:0] req, logic [ID_W-1:0] bid,
                             output out_item_t pred);
        in_item_t it;
        it = '{func: func, req_size: req, block_id: bid};
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = func ? predict_free(bid) : predict_alloc(req);
        pending_results = {pending_results, pred};
    endtask

    task automatic send_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycles % 97 < 60) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with none expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_data.status);
                    errors++;
                end
                if (m_data.new_id !== want.new_id) begin
                    $error("new_id expected %0d actual %0d", want.new_id, m_data.new_id);
                    errors++;
                end
                if (m_data.start_addr !== want.start_addr) begin
                    $error("start_addr expected %0d actual %0d", want.start_addr,
                           m_data.start_addr);
                    errors++;
                end
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_free_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || live_ids.size() == 0) return ID_W'($urandom);
        if (r == 1) return '0;
        r = $urandom_range(0, live_ids.size() - 1);
        pick_free_id = live_ids[r];
        live_ids.delete(r);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return ADDR_W'($urandom);
            1: return '0;
            2, 3: return ADDR_W'($urandom_range(1, 4));
            default: return ADDR_W'($urandom_range(1, region / 40 + 1));
        endcase
    endfunction

    row_t directed[] = '{
        '{1'b0, 16'd0,     16'd0,     1'b1, ST_NOFIT, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd0,     1'b1, ST_BADID, 16'd0, 16'd0},
        '{1'b0, 16'd100,   16'd0,     1'b1, ST_ALLOC, 16'd1, 16'd0},
        '{1'b0, 16'd200,   16'hFFFF,  1'b1, ST_ALLOC, 16'd2, 16'd100},
        '{1'b1, 16'hFFFF,  16'hFFFF,  1'b1, ST_BADID, 16'd0, 16'd0},
        '{1'b0, 16'hFFFF,  16'd0,     1'b1, ST_NOFIT, 16'd0, 16'd0},
        '{1'b0, 16'd50,    16'd0,     1'b0, ST_ALLOC, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd1,     1'b1, ST_FREED, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd1,     1'b1, ST_BADID, 16'd0, 16'd0},
        '{1'b0, 16'd30,    16'd0,     1'b0, ST_ALLOC, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd2,     1'b0, ST_FREED, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd3,     1'b0, ST_FREED, 16'd0, 16'd0},
        '{1'b1, 16'd0,     16'd4,     1'b0, ST_FREED, 16'd0, 16'd0},
        '{1'b0, 16'hFFFF,  16'd0,     1'b1, ST_ALLOC, 16'd5, 16'd0}
    };

    initial begin
        out_item_t pred;
        int sent;
        int burst;
        int phase;
        bit held;
        logic func;
        fit_sel = FIT_FIRST;
        region = REGION_RESET;
        table_init();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_item(directed[i].func, directed[i].req, directed[i].bid, pred);
            if (directed[i].known && (pred.status !== directed[i].st
                    || pred.new_id !== directed[i].nid
                    || pred.start_addr !== directed[i].saddr)) begin
                pending_results[$] = '{status: directed[i].st, new_id: directed[i].nid,
                                       start_addr: directed[i].saddr};
            end
        end
        send_gap(1);
        wait_drained();

        // Table full and exact fit in a full table, then zero region and fit mode 3.
        write_reg(CFG_REGION, 16'd200);
        for (int i = 0; i < 66; i++) send_item(1'b0, 16'd1, '0, pred);
        send_item(1'b0, 16'd137, '0, pred);
        send_item(1'b1, '0, 16'd10, pred);
        send_item(1'b0, 16'd1, '0, pred);
        send_gap(1);
        wait_drained();
        write_reg(CFG_REGION, 16'd0);
        send_item(1'b0, 16'd1, '0, pred);
        send_gap(1);
        wait_drained();
        write_reg(CFG_FIT, 16'd3);
        write_reg(CFG_REGION, 16'd500);
        send_item(1'b0, 16'd1, '0, pred);
        send_gap(1);
        wait_drained();

        // Random traffic, with the fit mode and region size changed every 400 items.
        sent = 0;
        phase = 0;
        held = 1'b0;
        while (sent < 1600) begin
            if (sent >= phase * 400) begin
                send_gap(1);
                wait_drained();
                write_reg(CFG_FIT, CFG_DATA_W'(phase % 3));
                write_reg(CFG_REGION, (phase == 2) ? 16'hFFFF
                                                   : ADDR_W'($urandom_range(64, 4000)));
                phase++;
            end
            if (!held && sent >= 200) begin
                held = 1'b1;
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
                for (int k = 0; k < 10; k++) begin
                    send_item(1'b0, pick_size(), '0, pred);
                    sent++;
                end
            end
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                func = ($urandom_range(0, 99) < 45);
                send_item(func, func ? ADDR_W'($urandom) : pick_size(),
                          func ? pick_free_id() : ID_W'($urandom), pred);
                sent++;
            end
            send_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0);
        end
        send_gap(1);
        wait_drained();

        if (errors == 0) begin
            $display("variable_partition_allocator test passed");
        end else begin
            $display("variable_partition_allocator test failed");
        end
        $finish;
    end
endmodule
